[rtl/rlb_pkg.sv]
// ----------------------------------------------------------------------------
// rlb_pkg
// Shared types, field widths and helpers of the replica load balancer.
// ----------------------------------------------------------------------------
package rlb_pkg;

    localparam int VID_W     = 32;
    localparam int MASK_W    = 16;
    localparam int ASSIGN_W  = 4;
    localparam int SLOT_W    = 10;
    localparam int PCOUNT_W  = 5;

    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 5'd16;

    localparam int DEF_MAX_VERTICES   = 1024;
    localparam int DEF_NUM_PARTITIONS = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_RDOUT   = 5'b00010,
        S_RECOUNT = 5'b00100,
        S_FIND    = 5'b01000,
        S_SWEEP   = 5'b10000
    } state_t;

    typedef struct packed {
        logic [MASK_W-1:0]   mask;
        logic [ASSIGN_W-1:0] part;
    } slot_entry_t;

    function automatic logic [ASSIGN_W-1:0] lowest_part(input logic [MASK_W-1:0] m);
        logic [ASSIGN_W-1:0] p;
        p = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                p = ASSIGN_W'(i);
            end
        end
        return p;
    endfunction

endpackage

[rtl/replica_load_balancer.sv]
// ----------------------------------------------------------------------------
// replica_load_balancer
// Loads are taken while idle. Reads: the slot is read into registers, then the result
// beat is loaded from them and the next item is taken, unless the previous beat is held.
// After the last load a recount rebuilds the loads, then each pass scans partition_count
// loads and sweeps the loaded slots, moving items off the busiest (one memory read a cycle).
// Reset clears counts, loads and flags; the slot memories need no clearing.
// ----------------------------------------------------------------------------
module replica_load_balancer
    import rlb_pkg::*;
#(
    parameter int MAX_VERTICES   = DEF_MAX_VERTICES,
    parameter int NUM_PARTITIONS = DEF_NUM_PARTITIONS
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_write,
    input  logic [PCOUNT_W-1:0] cfg_data,

    input  logic                item_valid,
    output logic                item_ready,
    input  logic                opcode,
    input  logic [VID_W-1:0]    vertex_id,
    input  logic [MASK_W-1:0]   allowed_mask,
    input  logic                last_vertex,
    input  logic [SLOT_W-1:0]   slot_index,

    output logic                result_valid,
    input  logic                result_ready,
    output logic [VID_W-1:0]    vertex_id_out,
    output logic [ASSIGN_W-1:0] assigned_partition,
    output logic                slot_valid,
    output logic                overflow
);

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int PIW = $clog2(NUM_PARTITIONS);
    localparam int PCW = ($clog2(NUM_PARTITIONS + 1) > PCOUNT_W) ?
                         $clog2(NUM_PARTITIONS + 1) : PCOUNT_W;
    localparam int XW  = (CW > SLOT_W) ? CW : SLOT_W;
    localparam int XPW = (PIW > ASSIGN_W) ? PIW : ASSIGN_W;
    localparam int MASK_PARTS = (NUM_PARTITIONS < MASK_W) ? NUM_PARTITIONS : MASK_W;
    localparam logic [MASK_W-1:0] LANE_MASK = (NUM_PARTITIONS >= MASK_W) ?
        {MASK_W{1'b1}} : MASK_W'((64'd1 << NUM_PARTITIONS) - 64'd1);

    state_t              state_reg, state_next;
    logic [PCOUNT_W-1:0] pcount_reg;
    logic [PCW-1:0]      pc_reg, pc_next, pc_eff;
    logic [CW-1:0]       loaded_count_reg, loaded_count_next;
    logic                overflow_flag_reg, overflow_flag_next;
    logic [CW-1:0]       load_reg [NUM_PARTITIONS];
    logic [CW-1:0]       load_next [NUM_PARTITIONS];
    logic [CW-1:0]       rd_idx_reg, rd_idx_next;
    logic                p1_valid_reg, p1_valid_next;
    logic [AW-1:0]       p1_idx_reg, p1_idx_next;
    logic [PCW-1:0]      scan_idx_reg, scan_idx_next;
    logic [PIW-1:0]      pmax_reg, pmax_next;
    logic [CW-1:0]       minl_reg, minl_next;
    logic [CW-1:0]       maxl_reg, maxl_next;
    logic                moved_reg, moved_next;
    logic                rd_ok_reg, rd_ok_next;

    logic                result_valid_reg;
    logic [VID_W-1:0]    vertex_id_out_reg;
    logic [ASSIGN_W-1:0] assigned_partition_reg;
    logic                slot_valid_reg;
    logic                overflow_reg;
    logic                res_load;

    logic [VID_W-1:0]    vid_mem [MAX_VERTICES];
    logic [VID_W-1:0]    vid_rdata_reg;
    slot_entry_t         slot_mem [MAX_VERTICES];
    slot_entry_t         slot_rdata_reg;

    logic                vid_we, vid_re, slot_we, slot_re;
    logic [AW-1:0]       wr_addr, rd_addr;
    slot_entry_t         slot_wdata;

    logic                load_clear, inc_en, dec_en;
    logic [ASSIGN_W-1:0] inc_part;

    logic [MASK_W-1:0]   mask_in;
    logic [CW-1:0]       scan_load;
    logic [MASK_W-1:0]   elig;
    logic [ASSIGN_W-1:0] target;
    logic                hit_pmax;

    assign item_ready         = (state_reg == S_IDLE);
    assign result_valid       = result_valid_reg;
    assign vertex_id_out      = vertex_id_out_reg;
    assign assigned_partition = assigned_partition_reg;
    assign slot_valid         = slot_valid_reg;
    assign overflow           = overflow_reg;

    assign mask_in   = allowed_mask & LANE_MASK;
    assign scan_load = load_reg[scan_idx_reg[PIW-1:0]];
    assign hit_pmax  = (XPW'(slot_rdata_reg.part) == XPW'(pmax_reg));
    assign target    = lowest_part(elig);

    always_comb
    begin
        if (pcount_reg == '0)
        begin
            pc_eff = PCW'(1);
        end
        else if (PCW'(pcount_reg) > PCW'(NUM_PARTITIONS))
        begin
            pc_eff = PCW'(NUM_PARTITIONS);
        end
        else
        begin
            pc_eff = PCW'(pcount_reg);
        end
    end

    // partitions in the mask whose load is at least two below the busiest
    always_comb
    begin
        elig = '0;
        for (int i = 0; i < MASK_PARTS; i++)
        begin
            elig[i] = slot_rdata_reg.mask[i] &&
                      (({1'b0, load_reg[i]} + (CW+1)'(1)) < {1'b0, maxl_reg});
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_PARTITIONS; j++)
        begin
            load_next[j] = load_reg[j];
            if (load_clear)
            begin
                load_next[j] = '0;
            end
            else
            begin
                if (inc_en && (XPW'(inc_part) == XPW'(j)))
                begin
                    load_next[j] = load_next[j] + CW'(1);
                end
                if (dec_en && (pmax_reg == PIW'(j)))
                begin
                    load_next[j] = load_next[j] - CW'(1);
                end
            end
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        pc_next            = pc_reg;
        loaded_count_next  = loaded_count_reg;
        overflow_flag_next = overflow_flag_reg;
        rd_idx_next        = rd_idx_reg;
        p1_valid_next      = 1'b0;
        p1_idx_next        = p1_idx_reg;
        scan_idx_next      = scan_idx_reg;
        pmax_next          = pmax_reg;
        minl_next          = minl_reg;
        maxl_next          = maxl_reg;
        moved_next         = moved_reg;
        rd_ok_next         = rd_ok_reg;
        res_load           = 1'b0;
        vid_we             = 1'b0;
        vid_re             = 1'b0;
        slot_we            = 1'b0;
        slot_re            = 1'b0;
        wr_addr            = p1_idx_reg;
        rd_addr            = rd_idx_reg[AW-1:0];
        slot_wdata         = slot_rdata_reg;
        load_clear         = 1'b0;
        inc_en             = 1'b0;
        dec_en             = 1'b0;
        inc_part           = lowest_part(slot_rdata_reg.mask);

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (opcode == OP_LOAD)
                    begin
                        if (mask_in != '0)
                        begin
                            if (loaded_count_reg < CW'(MAX_VERTICES))
                            begin
                                wr_addr           = loaded_count_reg[AW-1:0];
                                vid_we            = 1'b1;
                                slot_we           = 1'b1;
                                slot_wdata.mask   = mask_in;
                                slot_wdata.part   = lowest_part(mask_in);
                                inc_en            = 1'b1;
                                inc_part          = lowest_part(mask_in);
                                loaded_count_next = loaded_count_reg + CW'(1);
                            end
                            else
                            begin
                                overflow_flag_next = 1'b1;
                            end
                        end
                        if (last_vertex)
                        begin
                            state_next  = S_RECOUNT;
                            pc_next     = pc_eff;
                            load_clear  = 1'b1;
                            rd_idx_next = '0;
                        end
                    end
                    else
                    begin
                        rd_addr    = AW'(slot_index);
                        vid_re     = 1'b1;
                        slot_re    = 1'b1;
                        rd_ok_next = (XW'(slot_index) < XW'(loaded_count_reg));
                        state_next = S_RDOUT;
                    end
                end
            end

            S_RDOUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_RECOUNT, S_SWEEP:
            begin
                if (rd_idx_reg < loaded_count_reg)
                begin
                    slot_re       = 1'b1;
                    rd_idx_next   = rd_idx_reg + CW'(1);
                    p1_valid_next = 1'b1;
                    p1_idx_next   = rd_idx_reg[AW-1:0];
                end

                // write-back address trails the read address, so no overlap
                if (p1_valid_reg)
                begin
                    if (state_reg == S_RECOUNT)
                    begin
                        slot_we         = 1'b1;
                        slot_wdata.part = lowest_part(slot_rdata_reg.mask);
                        inc_en          = 1'b1;
                    end
                    else if (hit_pmax && (elig != '0))
                    begin
                        slot_we         = 1'b1;
                        slot_wdata.part = target;
                        inc_en          = 1'b1;
                        inc_part        = target;
                        dec_en          = 1'b1;
                        maxl_next       = maxl_reg - CW'(1);
                        moved_next      = 1'b1;
                    end
                end
                else if (rd_idx_reg == loaded_count_reg)
                begin
                    if ((state_reg == S_RECOUNT) || moved_reg)
                    begin
                        state_next    = S_FIND;
                        scan_idx_next = PCW'(1);
                        pmax_next     = '0;
                        minl_next     = load_reg[0];
                        maxl_next     = load_reg[0];
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_FIND:
            begin
                if (scan_idx_reg < pc_reg)
                begin
                    if (scan_load < minl_reg)
                    begin
                        minl_next = scan_load;
                    end
                    if (scan_load > maxl_reg)
                    begin
                        maxl_next = scan_load;
                        pmax_next = scan_idx_reg[PIW-1:0];
                    end
                    scan_idx_next = scan_idx_reg + PCW'(1);
                end
                else if ({1'b0, maxl_reg} > ({1'b0, minl_reg} + (CW+1)'(1)))
                begin
                    state_next  = S_SWEEP;
                    rd_idx_next = '0;
                    moved_next  = 1'b0;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            pcount_reg        <= PCOUNT_RESET;
            pc_reg            <= PCW'(1);
            loaded_count_reg  <= '0;
            overflow_flag_reg <= 1'b0;
            for (int j = 0; j < NUM_PARTITIONS; j++)
            begin
                load_reg[j] <= '0;
            end
            rd_idx_reg        <= '0;
            p1_valid_reg      <= 1'b0;
            p1_idx_reg        <= '0;
            scan_idx_reg      <= '0;
            pmax_reg          <= '0;
            minl_reg          <= '0;
            maxl_reg          <= '0;
            moved_reg         <= 1'b0;
            rd_ok_reg         <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            if (cfg_write)
            begin
                pcount_reg <= cfg_data;
            end
            pc_reg            <= pc_next;
            loaded_count_reg  <= loaded_count_next;
            overflow_flag_reg <= overflow_flag_next;
            for (int j = 0; j < NUM_PARTITIONS; j++)
            begin
                load_reg[j] <= load_next[j];
            end
            rd_idx_reg        <= rd_idx_next;
            p1_valid_reg      <= p1_valid_next;
            p1_idx_reg        <= p1_idx_next;
            scan_idx_reg      <= scan_idx_next;
            pmax_reg          <= pmax_next;
            minl_reg          <= minl_next;
            maxl_reg          <= maxl_next;
            moved_reg         <= moved_next;
            rd_ok_reg         <= rd_ok_next;
            if (res_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            vertex_id_out_reg      <= rd_ok_reg ? vid_rdata_reg : '0;
            assigned_partition_reg <= rd_ok_reg ? slot_rdata_reg.part : '0;
            slot_valid_reg         <= rd_ok_reg;
            overflow_reg           <= overflow_flag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vid_we)
        begin
            vid_mem[wr_addr] <= vertex_id;
        end
        if (vid_re)
        begin
            vid_rdata_reg <= vid_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[wr_addr] <= slot_wdata;
        end
        if (slot_re)
        begin
            slot_rdata_reg <= slot_mem[rd_addr];
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_count_reg <= CW'(MAX_VERTICES))
        else $error("loaded count beyond table size");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_RDOUT))
        else $error("result beat without a read");

    a_find_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND) |-> (maxl_reg >= minl_reg))
        else $error("busiest load below least load");

    a_move_target: assert property (@(posedge clk) disable iff (!rst_n)
        dec_en |-> (XPW'(inc_part) != XPW'(pmax_reg)))
        else $error("move onto the busiest partition");

    a_pipe_state: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg |-> ((state_reg == S_RECOUNT) || (state_reg == S_SWEEP)))
        else $error("sweep data outside a sweep");
`endif

endmodule
